/* rtl/core/sue_pkg.sv */
// ----------------------------------------------------------------------------
// sue_pkg: shared types and constants of the symmetrical uncertainty engine
// Command and status groups between controller and datapath, status codes
// and the log2 fraction table generator.
// ----------------------------------------------------------------------------
package sue_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SU_BITS   = 16;
	localparam int SU_SHIFT  = 15;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_NOENT = 2'd2;

	typedef enum logic [1:0] {
		TS_A,
		TS_B,
		TS_J
	} tsel_t;

	typedef struct packed {
		logic  clr_all;
		logic  sweep_rd;
		logic  log_m;
		tsel_t tsel;
		logic  acc_clr;
		logic  div_ent;
		logic  store_h;
		logic  div_su;
		logic  fin;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_busy;
		logic out_busy;
	} stat_t;

	// 16 fraction bits of log2(1 + i/2^tb) by square-and-compare on Q2.30
	function automatic logic [FRAC_BITS-1:0] log_frac(input int i, input int tb);
		logic [63:0]          x;
		logic [FRAC_BITS-1:0] f;
		x = (64'd1 << 30) + ((64'(i) << 30) >> tb);
		f = '0;
		for (int k = 0; k < FRAC_BITS; k++) begin
			x = (x * x) >> 30;
			f = f << 1;
			if (x >= (64'd2 << 30)) begin
				f[0] = 1'b1;
				x    = x >> 1;
			end
		end
		return f;
	endfunction

endpackage

/* rtl/core/sue_if.sv */
// ----------------------------------------------------------------------------
// sue_if: row and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface sue_row_if;
	logic       valid;
	logic       ready;
	logic [3:0] value_a;
	logic [3:0] value_b;
	logic       last_row;

	modport source (output valid, value_a, value_b, last_row, input ready);
	modport sink   (input valid, value_a, value_b, last_row, output ready);
endinterface

interface sue_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] uncertainty;
	logic [1:0]  status;
	logic [15:0] row_total;

	modport source (output valid, uncertainty, status, row_total, input ready);
	modport sink   (input valid, uncertainty, status, row_total, output ready);
endinterface

/* rtl/core/sue_div.sv */
// ----------------------------------------------------------------------------
// sue_div: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module sue_div #(
	parameter int NW = 37,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          qbit;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
endmodule

/* rtl/core/sue_ctrl.sv */
// ----------------------------------------------------------------------------
// sue_ctrl: sequencer of the engine
// Clear pass, row loading, histogram sweeps, divisions and result hand-off.
// ----------------------------------------------------------------------------
module sue_ctrl #(
	parameter int NV = 16,
	parameter int JW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	input  sue_pkg::stat_t stat,
	output logic          in_ready,
	output sue_pkg::cmd_t cmd,
	output logic [JW-1:0] idx
);
	import sue_pkg::*;

	localparam int NJ = NV * NV;

	typedef enum logic [3:0] {
		CLR, LOAD, DRAIN, LOGM, SWEEP, WAITP, DIVS, WAITD, STOREH, SUDIV, WAITSU, FIN
	} state_t;

	state_t        state_q;
	logic [JW-1:0] idx_q;
	tsel_t         tsel_q;
	logic [JW-1:0] last_idx;

	always_comb begin
		last_idx = (tsel_q == TS_J) ? JW'(NJ - 1) : JW'(NV - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			idx_q   <= '0;
			tsel_q  <= TS_A;
		end else begin
			unique case (state_q)
				CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == JW'(NJ - 1)) begin
						idx_q   <= '0;
						state_q <= LOAD;
					end
				end
				LOAD: begin
					if (in_valid && in_last) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: state_q <= LOGM;
				LOGM: begin
					tsel_q  <= TS_A;
					idx_q   <= '0;
					state_q <= SWEEP;
				end
				SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == last_idx) begin
						state_q <= WAITP;
					end
				end
				WAITP: begin
					if (!stat.pipe_busy) begin
						state_q <= DIVS;
					end
				end
				DIVS: state_q <= WAITD;
				WAITD: begin
					if (!stat.div_busy) begin
						state_q <= STOREH;
					end
				end
				STOREH: begin
					idx_q <= '0;
					unique case (tsel_q)
						TS_A:    begin tsel_q <= TS_B; state_q <= SWEEP; end
						TS_B:    begin tsel_q <= TS_J; state_q <= SWEEP; end
						default: state_q <= SUDIV;
					endcase
				end
				SUDIV: state_q <= WAITSU;
				WAITSU: begin
					if (!stat.div_busy && !stat.out_busy) begin
						state_q <= FIN;
					end
				end
				FIN: state_q <= LOAD;
				default: state_q <= CLR;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.tsel     = tsel_q;
		cmd.clr_all  = (state_q == CLR);
		cmd.sweep_rd = (state_q == SWEEP);
		cmd.log_m    = (state_q == LOGM);
		cmd.acc_clr  = (state_q == LOGM) || (state_q == STOREH);
		cmd.div_ent  = (state_q == DIVS);
		cmd.store_h  = (state_q == STOREH);
		cmd.div_su   = (state_q == SUDIV);
		cmd.fin      = (state_q == FIN);
		in_ready     = (state_q == LOAD);
	end

	assign idx = idx_q;
endmodule

/* rtl/core/sue_dp.sv */
// ----------------------------------------------------------------------------
// sue_dp: datapath of the engine
// Histogram memories with forwarded increments, log2 pipeline, accumulator,
// shared divider, entropy registers and the result register.
// ----------------------------------------------------------------------------
module sue_dp #(
	parameter int NV  = 16,
	parameter int CB  = 16,
	parameter int LTD = 1024,
	parameter int JW  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sue_pkg::cmd_t cmd,
	input  logic [JW-1:0] idx,
	input  logic          accept,
	input  logic [3:0]    value_a,
	input  logic [3:0]    value_b,
	input  logic          res_ready,
	output sue_pkg::stat_t stat,
	output logic          res_valid,
	output logic [15:0]   uncertainty,
	output logic [1:0]    status,
	output logic [15:0]   row_total
);
	import sue_pkg::*;

	localparam int NJ  = NV * NV;
	localparam int VB  = $clog2(NV);
	localparam int TB  = $clog2(LTD + 1) - 1;
	localparam int TD  = 1 << TB;
	localparam int PB  = $clog2(CB);
	localparam int LW  = PB + FRAC_BITS;
	localparam int SW  = CB + LW;
	localparam int DNW = (SW > LW + SU_SHIFT + 2) ? SW : LW + SU_SHIFT + 2;
	localparam int DDW = (CB > LW + 1) ? CB : LW + 1;

	// histogram stores
	logic [CB-1:0] mem_j [NJ];
	logic [CB-1:0] mem_a [NV];
	logic [CB-1:0] mem_b [NV];
	logic [CB-1:0] rd_j_q, rd_a_q, rd_b_q;

	logic [CB-1:0] row_count_q;
	logic          sat_q;
	logic [VB-1:0] a_in, b_in;
	logic [JW-1:0] j_in;
	logic          cnt_en;

	logic          ld_v_s1;
	logic [VB-1:0] aa_s1, ab_s1;
	logic [JW-1:0] aj_s1;
	logic          lw_v_q;
	logic [VB-1:0] lwa_q, lwb_q;
	logic [JW-1:0] lwj_q;
	logic [CB-1:0] lva_q, lvb_q, lvj_q;
	logic [CB-1:0] nva, nvb, nvj;
	logic [VB-1:0] ra, rb;
	logic [JW-1:0] rj;

	always_comb begin
		a_in   = (32'(value_a) >= NV) ? VB'(NV - 1) : VB'(value_a);
		b_in   = (32'(value_b) >= NV) ? VB'(NV - 1) : VB'(value_b);
		j_in   = JW'(a_in) * JW'(NV) + JW'(b_in);
		cnt_en = accept && (row_count_q != {CB{1'b1}});
		ra     = cmd.sweep_rd ? idx[VB-1:0] : a_in;
		rb     = cmd.sweep_rd ? idx[VB-1:0] : b_in;
		rj     = cmd.sweep_rd ? idx : j_in;
		// forward the write of the previous row, which the read missed
		nva = ((lw_v_q && lwa_q == aa_s1) ? lva_q : rd_a_q) + 1'b1;
		nvb = ((lw_v_q && lwb_q == ab_s1) ? lvb_q : rd_b_q) + 1'b1;
		nvj = ((lw_v_q && lwj_q == aj_s1) ? lvj_q : rd_j_q) + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_all || (cmd.sweep_rd && cmd.tsel == TS_J)) begin
			mem_j[idx] <= '0;
		end else if (ld_v_s1) begin
			mem_j[aj_s1] <= nvj;
		end
		rd_j_q <= mem_j[rj];
	end

	always_ff @(posedge clk) begin
		if ((cmd.clr_all && 32'(idx) < NV) || (cmd.sweep_rd && cmd.tsel == TS_A)) begin
			mem_a[idx[VB-1:0]] <= '0;
		end else if (ld_v_s1) begin
			mem_a[aa_s1] <= nva;
		end
		rd_a_q <= mem_a[ra];
	end

	always_ff @(posedge clk) begin
		if ((cmd.clr_all && 32'(idx) < NV) || (cmd.sweep_rd && cmd.tsel == TS_B)) begin
			mem_b[idx[VB-1:0]] <= '0;
		end else if (ld_v_s1) begin
			mem_b[ab_s1] <= nvb;
		end
		rd_b_q <= mem_b[rb];
	end

	always_ff @(posedge clk) begin
		aa_s1 <= a_in;
		ab_s1 <= b_in;
		aj_s1 <= j_in;
		lwa_q <= aa_s1;
		lwb_q <= ab_s1;
		lwj_q <= aj_s1;
		lva_q <= nva;
		lvb_q <= nvb;
		lvj_q <= nvj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1     <= 1'b0;
			lw_v_q      <= 1'b0;
			row_count_q <= '0;
			sat_q       <= 1'b0;
		end else begin
			ld_v_s1 <= cnt_en;
			lw_v_q  <= ld_v_s1;
			if (cmd.fin) begin
				row_count_q <= '0;
				sat_q       <= 1'b0;
			end else if (cnt_en) begin
				row_count_q <= row_count_q + 1'b1;
			end else if (accept) begin
				sat_q <= 1'b1;
			end
		end
	end

	// log2 and c*log2(c) pipeline
	logic [FRAC_BITS-1:0] log_tbl [TD];

	always_comb begin
		for (int i = 0; i < TD; i++) begin
			log_tbl[i] = log_frac(i, TB);
		end
	end

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic          lm_s1, lm_s2, lm_s3, lm_s4, lm_s5;
	tsel_t         tsel_s1;
	logic [CB-1:0] c1;
	logic [PB-1:0] p1;
	logic [CB-1:0] c_s2, c_s3, c_s4;
	logic [PB-1:0] p_s2, p_s3;
	logic [CB-1:0] norm2;
	logic [CB+TB-1:0] ext2;
	logic [FRAC_BITS-1:0] frac_s3;
	logic [LW-1:0] l3;
	logic [LW-1:0] l_s4;
	logic [SW-1:0] prod_s5;
	logic [SW-1:0] acc_q;
	logic [LW-1:0] lm_q;

	always_comb begin
		unique case (tsel_s1)
			TS_A:    c1 = rd_a_q;
			TS_B:    c1 = rd_b_q;
			default: c1 = rd_j_q;
		endcase
		if (lm_s1) begin
			c1 = row_count_q;
		end
		p1 = '0;
		for (int i = 0; i < CB; i++) begin
			if (c1[i]) begin
				p1 = PB'(i);
			end
		end
		norm2 = c_s2 << (PB'(CB - 1) - p_s2);
		ext2  = {norm2, {TB{1'b0}}};
		l3    = (c_s3 == '0) ? '0 : {p_s3, frac_s3};
	end

	always_ff @(posedge clk) begin
		tsel_s1 <= cmd.tsel;
		c_s2    <= c1;
		p_s2    <= p1;
		c_s3    <= c_s2;
		p_s3    <= p_s2;
		frac_s3 <= log_tbl[ext2[CB+TB-2 -: TB]];
		c_s4    <= c_s3;
		l_s4    <= l3;
		prod_s5 <= SW'(c_s4) * SW'(l_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5}      <= '0;
			{lm_s1, lm_s2, lm_s3, lm_s4, lm_s5} <= '0;
			acc_q <= '0;
			lm_q  <= '0;
		end else begin
			v_s1  <= cmd.sweep_rd || cmd.log_m;
			lm_s1 <= cmd.log_m;
			{v_s2, v_s3, v_s4, v_s5}      <= {v_s1, v_s2, v_s3, v_s4};
			{lm_s2, lm_s3, lm_s4, lm_s5}  <= {lm_s1, lm_s2, lm_s3, lm_s4};
			if (v_s4 && lm_s4) begin
				lm_q <= l_s4;
			end
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end else if (v_s5 && !lm_s5) begin
				acc_q <= acc_q + prod_s5;
			end
		end
	end

	// divisions and entropies
	logic [DNW-1:0] div_num;
	logic [DDW-1:0] div_den;
	logic           div_busy;
	logic [DNW-1:0] quot;
	logic [LW-1:0]  ha_q, hb_q, hab_q;
	logic [LW-1:0]  h_new;
	logic [LW:0]    den_su;
	logic [LW+1:0]  num_su;

	always_comb begin
		den_su = {1'b0, ha_q} + {1'b0, hb_q};
		num_su = (den_su > {1'b0, hab_q}) ? {(den_su - {1'b0, hab_q}), 1'b0} : '0;
		if (cmd.div_su) begin
			div_num = DNW'({num_su, {SU_SHIFT{1'b0}}});
			div_den = DDW'(den_su);
		end else begin
			div_num = DNW'(acc_q);
			div_den = DDW'(row_count_q);
		end
		if (row_count_q == '0 || quot > DNW'(lm_q)) begin
			h_new = '0;
		end else begin
			h_new = lm_q - quot[LW-1:0];
		end
	end

	sue_div #(.NW(DNW), .DW(DDW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_ent || cmd.div_su),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.store_h) begin
			unique case (cmd.tsel)
				TS_A:    ha_q  <= h_new;
				TS_B:    hb_q  <= h_new;
				default: hab_q <= h_new;
			endcase
		end
	end

	// result register
	logic        out_v_q;
	logic [15:0] su_q, rt_q;
	logic [1:0]  st_q;
	logic [31:0] rc32;

	assign rc32 = 32'(row_count_q);

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (den_su == '0) begin
				su_q <= '0;
			end else if (quot > DNW'(32768)) begin
				su_q <= 16'h8000;
			end else begin
				su_q <= quot[SU_BITS-1:0];
			end
			if (sat_q) begin
				st_q <= ST_SAT;
			end else if (den_su == '0) begin
				st_q <= ST_NOENT;
			end else begin
				st_q <= ST_OK;
			end
			rt_q <= (rc32 > 32'hFFFF) ? 16'hFFFF : rc32[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.fin) begin
			out_v_q <= 1'b1;
		end else if (res_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_comb begin
		stat.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
		stat.div_busy  = div_busy;
		stat.out_busy  = out_v_q;
	end

	assign res_valid   = out_v_q;
	assign uncertainty = su_q;
	assign status      = st_q;
	assign row_total   = rt_q;
endmodule

/* rtl/core/symmetrical_uncertainty_engine_core.sv */
// ----------------------------------------------------------------------------
// symmetrical_uncertainty_engine_core: symmetrical uncertainty of two columns
// Counts rows of two discrete values and emits 2*(HA+HB-HAB)/(HA+HB) in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   row: one transfer per data row (value_a, value_b, last_row). Rows are
//   taken at one per cycle while loading; each counted row bumps three
//   histograms via a read/increment/write path forwarding the previous write.
//   res: one transfer per data set, after the row marked last_row.
//   After the last row the engine stops taking rows while it sweeps the
//   histograms (marginal A, marginal B, joint) through a five-stage
//   c*log2(c) pipeline, clearing each entry as it is read, and runs four
//   divisions on a shared one-bit-per-cycle divider.
//   Reset: a clear pass over the NUM_VALUES^2 joint entries zeroes the
//   histograms; rows are held off until it ends.
//   Stall: the result sits in an output register until res.ready; rows of
//   the next data set are taken meanwhile, and its result waits for the slot.
// ----------------------------------------------------------------------------
module symmetrical_uncertainty_engine_core #(
	parameter int NUM_VALUES      = 16,
	parameter int COUNT_BITS      = 16,
	parameter int LOG_TABLE_DEPTH = 1024
) (
	input logic      clk,
	input logic      arst_n,
	sue_row_if.sink  row,
	sue_res_if.source res
);
	import sue_pkg::*;

	localparam int JW = $clog2(NUM_VALUES * NUM_VALUES);

	cmd_t          cmd;
	stat_t         stat;
	logic [JW-1:0] idx;
	logic          row_ready;
	logic          accept;

	// a row transfer
	assign accept    = row.valid && row_ready;
	assign row.ready = row_ready;

	sue_ctrl #(.NV(NUM_VALUES), .JW(JW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (row.valid),
		.in_last  (row.last_row),
		.stat     (stat),
		.in_ready (row_ready),
		.cmd      (cmd),
		.idx      (idx)
	);

	sue_dp #(
		.NV  (NUM_VALUES),
		.CB  (COUNT_BITS),
		.LTD (LOG_TABLE_DEPTH),
		.JW  (JW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.accept      (accept),
		.value_a     (row.value_a),
		.value_b     (row.value_b),
		.res_ready   (res.ready),
		.stat        (stat),
		.res_valid   (res.valid),
		.uncertainty (res.uncertainty),
		.status      (res.status),
		.row_total   (res.row_total)
	);

`ifndef NO_ASSERTIONS
	// result never exceeds 1.0
	a_su_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.uncertainty <= 16'h8000)
		else $error("uncertainty above 1.0");

	// no entropy gives a zero result
	a_noent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_NOENT |-> res.uncertainty == 16'd0)
		else $error("nonzero result with no entropy");

	// rows are never taken while a division or the log2 pipeline runs
	a_no_row_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		row.ready |-> !stat.div_busy && !stat.pipe_busy)
		else $error("row taken during computation");
`endif
endmodule
